// File: src/sha256_message_digest_core_assert.svh
// Assertion macros for the SHA-256 digest core.
`ifndef SHA256_MESSAGE_DIGEST_CORE_ASSERT_SVH
`define SHA256_MESSAGE_DIGEST_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define SMD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SMD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SMD_ASSERT_IMP(label, ante, cons, msg)
`define SMD_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// File: src/smd_pkg.sv
// Shared types, opcodes and constant tables for the SHA-256 digest core.
`timescale 1ns / 1ps
package smd_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        final_word;
    } t_out_item;

    // schedule window operations
    localparam logic [2:0] SCHED_OP_HOLD  = 3'd0;
    localparam logic [2:0] SCHED_OP_BYTE  = 3'd1;
    localparam logic [2:0] SCHED_OP_PAD   = 3'd2;
    localparam logic [2:0] SCHED_OP_ZERO  = 3'd3;
    localparam logic [2:0] SCHED_OP_SHIFT = 3'd4;

    // round unit operations
    localparam logic [2:0] RND_OP_HOLD = 3'd0;
    localparam logic [2:0] RND_OP_LOAD = 3'd1;
    localparam logic [2:0] RND_OP_STEP = 3'd2;
    localparam logic [2:0] RND_OP_FOLD = 3'd3;
    localparam logic [2:0] RND_OP_INIT = 3'd4;

    localparam logic [7:0] PAD_MARK    = 8'h80;
    localparam logic [5:0] LEN_POS     = 6'd56;
    localparam logic [5:0] LAST_POS    = 6'd63;
    localparam logic [5:0] LAST_ROUND  = 6'd63;
    localparam logic [2:0] LAST_WORD   = 3'd7;

    typedef struct packed {
        logic [2:0]  op;
        logic [5:0]  pos;
        logic [7:0]  data;
        logic        len_ins;
        logic [63:0] bit_len;
    } t_sched_ctrl;

    typedef struct packed {
        logic [2:0] op;
        logic [5:0] rnd;
        logic [2:0] out_idx;
    } t_rnd_ctrl;

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = 32'h6a09e667;
            3'd1:    v = 32'hbb67ae85;
            3'd2:    v = 32'h3c6ef372;
            3'd3:    v = 32'ha54ff53a;
            3'd4:    v = 32'h510e527f;
            3'd5:    v = 32'h9b05688c;
            3'd6:    v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        case (t)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

endpackage

// File: src/sha256_message_digest_core.sv
// Top level: byte intake, padding sequencer and digest output of the SHA-256 core.
// An item without a block completion leaves the core idle and ready; one that fills the buffer
// stalls the input for a load, 64 rounds on the single round unit and a fold into the chaining hash.
// A last item adds a pad step and a compression of the same kind, twice when the fill point
// is 56 or above, then eight output transfers, one digest word per transfer.
// Reset (synchronous, active low) loads the initial hash and clears the byte count;
// the block buffer is not cleared.
`timescale 1ns / 1ps
`include "sha256_message_digest_core_assert.svh"
module sha256_message_digest_core
    import smd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;
    localparam logic [2:0] ST_COMP = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [5:0]  r_rnd, n_rnd;
    logic [63:0] r_count, n_count;
    logic        r_last, n_last;
    logic        r_pad2, n_pad2;
    logic        r_len_done, n_len_done;
    logic [2:0]  r_oidx, n_oidx;

    t_sched_ctrl w_sched;
    t_rnd_ctrl   w_rnd;
    logic [31:0] w_w;
    logic [31:0] w_hash_word;

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = (r_state == ST_OUT);

    always_comb begin
        n_state    = r_state;
        n_rnd      = r_rnd;
        n_count    = r_count;
        n_last     = r_last;
        n_pad2     = r_pad2;
        n_len_done = r_len_done;
        n_oidx     = r_oidx;

        w_sched.op      = SCHED_OP_HOLD;
        w_sched.pos     = r_count[5:0];
        w_sched.data    = i_item.data_byte;
        w_sched.len_ins = 1'b0;
        w_sched.bit_len = {r_count[60:0], 3'b000};

        w_rnd.op      = RND_OP_HOLD;
        w_rnd.rnd     = r_rnd;
        w_rnd.out_idx = r_oidx;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_item.has_byte) begin
                        w_sched.op = SCHED_OP_BYTE;
                        n_count    = r_count + 64'd1;
                    end
                    if (i_item.has_byte && r_count[5:0] == LAST_POS) begin
                        // buffer full: compress before any padding
                        w_rnd.op = RND_OP_LOAD;
                        n_last   = i_item.is_last;
                        n_state  = ST_COMP;
                    end else if (i_item.is_last) begin
                        n_last  = 1'b1;
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (r_pad2) begin
                    w_sched.op = SCHED_OP_ZERO;
                    n_len_done = 1'b1;
                end else begin
                    w_sched.op = SCHED_OP_PAD;
                    if (r_count[5:0] < LEN_POS) begin
                        w_sched.len_ins = 1'b1;
                        n_len_done      = 1'b1;
                    end else begin
                        // no room for the length: it goes in a second block
                        n_pad2 = 1'b1;
                    end
                end
                w_rnd.op = RND_OP_LOAD;
                n_rnd    = '0;
                n_state  = ST_COMP;
            end
            ST_COMP: begin
                w_sched.op = SCHED_OP_SHIFT;
                w_rnd.op   = RND_OP_STEP;
                n_rnd      = r_rnd + 6'd1;
                if (r_rnd == LAST_ROUND) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                w_rnd.op = RND_OP_FOLD;
                if (r_last && r_len_done) begin
                    n_oidx  = '0;
                    n_state = ST_OUT;
                end else if (r_last) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (!i_stall) begin
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == LAST_WORD) begin
                        w_rnd.op   = RND_OP_INIT;
                        n_count    = '0;
                        n_last     = 1'b0;
                        n_pad2     = 1'b0;
                        n_len_done = 1'b0;
                        n_state    = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_rnd      <= '0;
            r_count    <= '0;
            r_last     <= 1'b0;
            r_pad2     <= 1'b0;
            r_len_done <= 1'b0;
            r_oidx     <= '0;
        end else begin
            r_state    <= n_state;
            r_rnd      <= n_rnd;
            r_count    <= n_count;
            r_last     <= n_last;
            r_pad2     <= n_pad2;
            r_len_done <= n_len_done;
            r_oidx     <= n_oidx;
        end
    end

    smd_sched u_sched (
        .i_clk  (i_clk),
        .i_ctrl (w_sched),
        .o_w    (w_w)
    );

    smd_round u_round (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_rnd),
        .i_w         (w_w),
        .o_hash_word (w_hash_word)
    );

    assign o_item.digest_word = w_hash_word;
    assign o_item.word_index  = r_oidx;
    assign o_item.final_word  = (r_oidx == LAST_WORD);

    `SMD_ASSERT_IMP(a_no_ready_while_out, !o_stall, !o_valid, "input ready during digest output")
    `SMD_ASSERT_IMP(a_idle_clean, r_state == ST_IDLE, !r_last && !r_pad2 && !r_len_done && r_rnd == 6'd0, "stale padding flags while idle")
    `SMD_ASSERT_IMP(a_out_after_len, o_valid, r_last && r_len_done, "digest shown before length block compressed")
    `SMD_ASSERT_NXT(a_restart, o_valid && !i_stall && o_item.final_word, r_count == 64'd0 && !o_stall, "no clean restart after last digest word")

endmodule

// File: src/smd_sched.sv
// Block buffer held as a 16-word window that doubles as the message schedule.
`timescale 1ns / 1ps
module smd_sched
    import smd_pkg::*;
(
    input  logic        i_clk,
    input  t_sched_ctrl i_ctrl,
    output logic [31:0] o_w
);

    logic [31:0] r_win [16];
    logic [31:0] n_win [16];

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b0, x[31:3]};
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    always_comb begin
        logic [5:0] v_idx;
        v_idx = '0;
        for (int i = 0; i < 16; i++) begin
            n_win[i] = r_win[i];
        end
        unique case (i_ctrl.op)
            SCHED_OP_BYTE: begin
                for (int i = 0; i < 16; i++) begin
                    for (int b = 0; b < 4; b++) begin
                        v_idx = 6'(4 * i + b);
                        if (v_idx == i_ctrl.pos) begin
                            n_win[i][31 - 8 * b -: 8] = i_ctrl.data;
                        end
                    end
                end
            end
            SCHED_OP_PAD: begin
                // marker at the fill point, zeros behind it
                for (int i = 0; i < 16; i++) begin
                    for (int b = 0; b < 4; b++) begin
                        v_idx = 6'(4 * i + b);
                        if (v_idx == i_ctrl.pos) begin
                            n_win[i][31 - 8 * b -: 8] = PAD_MARK;
                        end else if (v_idx > i_ctrl.pos) begin
                            n_win[i][31 - 8 * b -: 8] = 8'h00;
                        end
                    end
                end
                if (i_ctrl.len_ins) begin
                    n_win[14] = i_ctrl.bit_len[63:32];
                    n_win[15] = i_ctrl.bit_len[31:0];
                end
            end
            SCHED_OP_ZERO: begin
                for (int i = 0; i < 14; i++) begin
                    n_win[i] = '0;
                end
                n_win[14] = i_ctrl.bit_len[63:32];
                n_win[15] = i_ctrl.bit_len[31:0];
            end
            SCHED_OP_SHIFT: begin
                for (int i = 0; i < 15; i++) begin
                    n_win[i] = r_win[i + 1];
                end
                n_win[15] = ssig1(r_win[14]) + r_win[9] + ssig0(r_win[1]) + r_win[0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 16; i++) begin
            r_win[i] <= n_win[i];
        end
    end

    assign o_w = r_win[0];

endmodule

// File: src/smd_round.sv
// Shared compression round unit with working variables and chaining hash.
`timescale 1ns / 1ps
module smd_round
    import smd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_rnd_ctrl   i_ctrl,
    input  logic [31:0] i_w,
    output logic [31:0] o_hash_word
);

    logic [31:0] r_chain [8];
    logic [31:0] r_v     [8];
    logic [31:0] w_t1;
    logic [31:0] w_t2;

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    always_comb begin
        w_t1 = r_v[7] + bsig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + round_k(i_ctrl.rnd) + i_w;
        w_t2 = bsig0(r_v[0])
             + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= init_hash(3'(i));
            end
        end else begin
            unique case (i_ctrl.op)
                RND_OP_FOLD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_chain[i] <= r_chain[i] + r_v[i];
                    end
                end
                RND_OP_INIT: begin
                    for (int i = 0; i < 8; i++) begin
                        r_chain[i] <= init_hash(3'(i));
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.op)
            RND_OP_LOAD: begin
                for (int i = 0; i < 8; i++) begin
                    r_v[i] <= r_chain[i];
                end
            end
            RND_OP_STEP: begin
                r_v[7] <= r_v[6];
                r_v[6] <= r_v[5];
                r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + w_t1;
                r_v[3] <= r_v[2];
                r_v[2] <= r_v[1];
                r_v[1] <= r_v[0];
                r_v[0] <= w_t1 + w_t2;
            end
            default: begin
            end
        endcase
    end

    assign o_hash_word = r_chain[i_ctrl.out_idx];

endmodule

// File: tb/tb_sha256_digest_pkg.sv
// Digest predictor and result scoreboard for the SHA-256 digest core testbench.
`timescale 1ns / 1ps
package tb_sha256_digest_pkg;
    import smd_pkg::*;

    localparam logic [31:0] SHA256_IV [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] SHA256_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    class digest_scoreboard;
        logic [31:0] hash_words [8];
        logic [7:0]  msg_block [64];
        logic [63:0] byte_count;
        t_out_item   pending_words [$];
        int          n_bad;

        function new();
            n_bad = 0;
            restart_message();
        endfunction

        function void restart_message();
            for (int i = 0; i < 8; i++) hash_words[i] = SHA256_IV[i];
            byte_count = '0;
        endfunction

        function logic [31:0] rotr(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress_block();
            logic [31:0] w [64];
            logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
            for (int i = 0; i < 16; i++)
                w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
            for (int i = 16; i < 64; i++)
                w[i] = (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                     + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
            {a, b, c, d} = {hash_words[0], hash_words[1], hash_words[2], hash_words[3]};
            {e, f, g, h} = {hash_words[4], hash_words[5], hash_words[6], hash_words[7]};
            for (int i = 0; i < 64; i++) begin
                t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                   + SHA256_K[i] + w[i];
                t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
                h = g; g = f; f = e; e = d + t1;
                d = c; c = b; b = a; a = t1 + t2;
            end
            hash_words[0] += a; hash_words[1] += b; hash_words[2] += c; hash_words[3] += d;
            hash_words[4] += e; hash_words[5] += f; hash_words[6] += g; hash_words[7] += h;
        endfunction

        // Absorb one accepted byte item; a last item pads and queues the eight digest words.
        function void take_message_item(t_in_item it);
            int          p;
            logic [63:0] bit_len;
            t_out_item   word;
            if (it.has_byte) begin
                p = int'(byte_count[5:0]);
                msg_block[p] = it.data_byte;
                byte_count += 64'd1;
                if (p == int'(LAST_POS)) compress_block();
            end
            if (!it.is_last) return;
            p = int'(byte_count[5:0]);
            msg_block[p] = PAD_MARK;
            for (int i = p + 1; i < 64; i++) msg_block[i] = 8'h00;
            // no room left for the length: pad spills into a second block
            if (p >= int'(LEN_POS)) begin
                compress_block();
                for (int i = 0; i < int'(LEN_POS); i++) msg_block[i] = 8'h00;
            end
            bit_len = byte_count << 3;
            for (int i = 0; i < 8; i++) msg_block[int'(LEN_POS) + i] = bit_len[63 - 8*i -: 8];
            compress_block();
            for (int i = 0; i < 8; i++) begin
                word.digest_word = hash_words[i];
                word.word_index  = 3'(i);
                word.final_word  = (3'(i) == LAST_WORD);
                pending_words.push_back(word);
            end
            restart_message();
        endfunction

        function void check_digest_word(t_out_item got);
            t_out_item want;
            if (pending_words.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("ERROR: unexpected digest word %h index %0d final %b",
                             got.digest_word, got.word_index, got.final_word);
                return;
            end
            want = pending_words.pop_front();
            if (got.digest_word !== want.digest_word || got.word_index !== want.word_index ||
                got.final_word !== want.final_word) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("ERROR: digest word exp %h/%0d/%b got %h/%0d/%b",
                             want.digest_word, want.word_index, want.final_word,
                             got.digest_word, got.word_index, got.final_word);
            end
        endfunction

        function int words_outstanding();
            return pending_words.size();
        endfunction
    endclass

endpackage

// File: tb/tb_sha256_message_digest_core.sv
// Top-level testbench: streams byte messages into the SHA-256 core and checks every digest word.
`timescale 1ns / 1ps
module tb_sha256_message_digest_core;
    import smd_pkg::*;
    import tb_sha256_digest_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEM_TARGET = 120;
    localparam int CALM_AFTER  = 120;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN_CYCLES = 150;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_item  i_item  = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_item o_item;

    digest_scoreboard sb = new();
    int  cycle_count  = 0;
    int  n_items      = 0;
    bit  calm         = 1'b0;
    bit  hold_pending = 1'b0;

    sha256_message_digest_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("sha256_message_digest_core test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_digest_word(o_item);
    end

    // Receiver back-pressure: random bursts, free-running stretches, one long hold-off.
    initial begin
        @(posedge i_clk);
        forever begin
            if (hold_pending) begin
                hold_pending = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 2) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    task automatic send_item(input logic [7:0] data, input logic has, input logic last);
        t_in_item it;
        it.data_byte = data;
        it.has_byte  = has;
        it.is_last   = last;
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_stall);
        sb.take_message_item(it);
        if (has || last) n_items++;
    endtask

    // One message of len random bytes; ends on the final byte or on an empty last transfer.
    task automatic send_message(input int len, input bit end_on_byte);
        for (int k = 0; k < len; k++) begin
            if (!calm && $urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, end_on_byte && (k == len - 1));
        end
        if (!end_on_byte || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
        calm = (n_items >= CALM_AFTER);
    endtask

    initial begin
        int boundary_len [2];
        int bi;
        int m;
        int len;
        boundary_len = '{56, 64};
        bi = 0;
        m  = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty message, idle transfers, single bytes at both extremes, a short text, a five-byte message
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h5a, 1'b0, 1'b0);
        send_item(8'ha5, 1'b0, 1'b0);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h01, 1'b1, 1'b0);
        send_item(8'h7f, 1'b1, 1'b0);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);

        // random messages, with the two-block padding case and a block-filling last byte
        while (n_items < ITEM_TARGET || bi < 2) begin
            if (m >= 1 && bi < 2) begin
                len = boundary_len[bi];
                bi++;
                if (len == 56) hold_pending = 1'b1;
                send_message(len, (len == 64) ? 1'b1 : 1'($urandom));
            end else begin
                len = $urandom_range(0, 20);
                send_message(len, 1'($urandom));
            end
            m++;
        end

        // closing message without idling on either side
        calm = 1'b1;
        send_message($urandom_range(10, 20), 1'($urandom));
        i_valid <= 1'b0;

        while (sb.words_outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.n_bad == 0 && sb.words_outstanding() == 0) begin
            $display("sha256_message_digest_core test passed");
        end else begin
            $display("sha256_message_digest_core test failed");
        end
        $finish;
    end

endmodule
